// ===== rtl/wtd_pkg.sv =====
// Whisker touch detector package: op codes, register indexes, field widths
// and the structs passed between the detector modules.
// No dependencies.
package wtd_pkg;

  typedef enum logic [1:0] {
    OP_BASELINE  = 2'd0,
    OP_CALIBRATE = 2'd1,
    OP_DETECT    = 2'd2,
    OP_RESET     = 2'd3
  } op_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRASP_MASK = 2'd2;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned PTR_W      = 4;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned RING_SLOTS = 16;
  localparam int unsigned UNIT_W     = 4;
  localparam int unsigned UMASK_W    = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned MAP_W      = 64;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned DEV_FRAC_W = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [THR_W-1:0] THR_RESET = 16'd256;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] peak;
  } chan_entry_t;

  localparam int unsigned CHAN_ENTRY_W = $bits(chan_entry_t);

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic              frame_end;
    logic              ch_ok;
    logic              peak_raise;
    logic [SUM_W-1:0]  dev;
    logic [PROD_W-1:0] prod;
  } s2_item_t;

endpackage

// ===== rtl/whisker_touch_detector_core.sv =====
// Whisker touch detector top level: config registers, ring pointers, stage one
// with forwarding, sample ring and channel RAMs. Depends on wtd_pkg, wtd_ram,
// wtd_update and wtd_frame.
// Path: a frame-end beat passes the stage-one, stage-two and result registers.
// Throughput: one beat per cycle while in_stall is low; the ring and channel RAMs
// each do one read and one write per cycle, with same-entry reuse forwarded from
// stage one. Reset: rst_n clears pointers, fill counts, channel-written flags,
// pipeline valids and flags; ring slots and channel entries read as zero until written.
module whisker_touch_detector_core #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned UNITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wtd_pkg::OP_W-1:0]          in_op,
  input  logic [wtd_pkg::CH_W-1:0]          in_channel,
  input  logic [wtd_pkg::SAMPLE_W-1:0]      in_sample_value,
  input  logic                              in_frame_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wtd_pkg::UMASK_W-1:0]       out_touched_units,
  output logic                              out_grasp_touched,
  output logic                              out_touch_started,
  output logic [wtd_pkg::COUNT_W-1:0]       out_touched_count,
  output logic                              out_peak_changed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wtd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RING_DEPTH = CHANNELS * wtd_pkg::RING_SLOTS;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned RA_FULL_W  = wtd_pkg::CH_W + wtd_pkg::PTR_W;

  // configuration
  logic [wtd_pkg::THR_W-1:0]   thr_r;
  logic [wtd_pkg::MAP_W-1:0]   umap_r;
  logic [wtd_pkg::UMASK_W-1:0] gmask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= wtd_pkg::THR_RESET;
      umap_r  <= '0;
      gmask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wtd_pkg::CFG_THRESHOLD:  thr_r   <= cfg_data[wtd_pkg::THR_W-1:0];
        wtd_pkg::CFG_UNIT_MAP:   umap_r  <= cfg_data;
        wtd_pkg::CFG_GRASP_MASK: gmask_r <= cfg_data[wtd_pkg::UMASK_W-1:0];
        default: ;
      endcase
    end
  end

  // accept side
  logic                          adv;
  logic                          accept;
  wtd_pkg::op_t                  in_op_e;
  logic                          in_ok;
  logic                          in_feed;
  logic                          in_chan_upd;
  logic [CH_AW-1:0]              in_idx;
  logic [wtd_pkg::PTR_W-1:0]     ptr_cur, ptr_nxt;
  logic [wtd_pkg::FILL_W-1:0]    fill_cur, fill_nxt;
  logic                          seen_cur;
  logic [RA_FULL_W-1:0]          ring_addr_full;
  logic [RING_AW-1:0]            ring_addr_in;
  logic                          slot_vld_in;

  logic [wtd_pkg::PTR_W-1:0]     ptr_r  [CHANNELS];
  logic [wtd_pkg::FILL_W-1:0]    fill_r [CHANNELS];
  logic                          seen_r [CHANNELS];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    in_op_e  = wtd_pkg::op_t'(in_op);
    in_ok    = {1'b0, in_channel} < (wtd_pkg::CH_W + 1)'(CHANNELS);
    in_feed  = in_ok && ((in_op_e == wtd_pkg::OP_BASELINE) ||
                         (in_op_e == wtd_pkg::OP_DETECT));
    in_chan_upd = in_ok && (in_op_e != wtd_pkg::OP_RESET);
    in_idx   = in_channel[CH_AW-1:0];
    ptr_cur  = ptr_r[in_idx];
    fill_cur = fill_r[in_idx];
    seen_cur = seen_r[in_idx];
    ptr_nxt  = (({1'b0, ptr_cur} + 5'd1) >= (wtd_pkg::PTR_W + 1)'(WINDOW)) ?
               '0 : ptr_cur + 4'd1;
    fill_nxt = (fill_cur < wtd_pkg::FILL_W'(WINDOW)) ? fill_cur + 5'd1 : fill_cur;
    slot_vld_in    = {1'b0, ptr_cur} < fill_cur;
    ring_addr_full = {in_channel, ptr_cur};
    ring_addr_in   = ring_addr_full[RING_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_r[i]  <= '0;
        fill_r[i] <= '0;
        seen_r[i] <= 1'b0;
      end
    end else if (accept) begin
      if (in_feed) begin
        ptr_r[in_idx]  <= ptr_nxt;
        fill_r[in_idx] <= fill_nxt;
      end
      if (in_chan_upd) begin
        seen_r[in_idx] <= 1'b1;
      end
    end
  end

  // stage one
  logic                          s1_valid_r;
  wtd_pkg::op_t                  s1_op_r;
  logic [wtd_pkg::CH_W-1:0]      s1_ch_r;
  logic [wtd_pkg::SAMPLE_W-1:0]  s1_x_r;
  logic                          s1_end_r;
  logic                          s1_ok_r;
  logic                          s1_slot_vld_r;
  logic                          s1_seen_r;
  logic [RING_AW-1:0]            s1_ring_addr_r;
  logic                          s1_fwd_chan_r, fwd_chan_nxt;
  logic                          s1_fwd_ring_r, fwd_ring_nxt;
  wtd_pkg::chan_entry_t          fwd_chan_data_r;
  logic [wtd_pkg::SAMPLE_W-1:0]  fwd_ring_data_r;

  logic                          s1_chan_we;
  logic                          s1_ring_we;
  logic [wtd_pkg::CHAN_ENTRY_W-1:0] chan_rdata;
  logic [wtd_pkg::SAMPLE_W-1:0]  ring_rdata;
  wtd_pkg::chan_entry_t          chan_cur;
  logic [wtd_pkg::SAMPLE_W-1:0]  ring_old;
  wtd_pkg::chan_entry_t          chan_wr;
  logic [wtd_pkg::SUM_W-1:0]     s1_dev;
  logic [wtd_pkg::PROD_W-1:0]    s1_prod;
  logic                          s1_raise;
  wtd_pkg::s2_item_t             s2_load;

  always_comb begin
    s1_chan_we = s1_valid_r && s1_ok_r && (s1_op_r != wtd_pkg::OP_RESET);
    s1_ring_we = s1_valid_r && s1_ok_r && ((s1_op_r == wtd_pkg::OP_BASELINE) ||
                                           (s1_op_r == wtd_pkg::OP_DETECT));
    fwd_chan_nxt = s1_chan_we && (s1_ch_r == in_channel);
    fwd_ring_nxt = s1_ring_we && (s1_ring_addr_r == ring_addr_in);
    if (s1_fwd_chan_r) begin
      chan_cur = fwd_chan_data_r;
    end else if (s1_seen_r) begin
      chan_cur = wtd_pkg::chan_entry_t'(chan_rdata);
    end else begin
      chan_cur = '0;
    end
    if (s1_fwd_ring_r) begin
      ring_old = fwd_ring_data_r;
    end else if (s1_slot_vld_r) begin
      ring_old = ring_rdata;
    end else begin
      ring_old = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s1_fwd_chan_r <= 1'b0;
      s1_fwd_ring_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r    <= in_valid;
      s1_fwd_chan_r <= fwd_chan_nxt;
      s1_fwd_ring_r <= fwd_ring_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r         <= in_op_e;
      s1_ch_r         <= in_channel;
      s1_x_r          <= in_sample_value;
      s1_end_r        <= in_frame_end;
      s1_ok_r         <= in_ok;
      s1_slot_vld_r   <= slot_vld_in;
      s1_seen_r       <= seen_cur;
      s1_ring_addr_r  <= ring_addr_in;
      fwd_chan_data_r <= chan_wr;
      fwd_ring_data_r <= s1_x_r;
    end
  end

  wtd_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (wtd_pkg::SAMPLE_W),
    .AW    (RING_AW)
  ) u_ring (
    .clk   (clk),
    .we    (adv && s1_ring_we),
    .waddr (s1_ring_addr_r),
    .wdata (s1_x_r),
    .re    (adv),
    .raddr (ring_addr_in),
    .rdata (ring_rdata)
  );

  wtd_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (wtd_pkg::CHAN_ENTRY_W),
    .AW    (CH_AW)
  ) u_chan (
    .clk   (clk),
    .we    (adv && s1_chan_we),
    .waddr (s1_ch_r[CH_AW-1:0]),
    .wdata (chan_wr),
    .re    (adv),
    .raddr (in_idx),
    .rdata (chan_rdata)
  );

  wtd_update #(
    .WINDOW (WINDOW)
  ) u_update (
    .op         (s1_op_r),
    .x          (s1_x_r),
    .cur        (chan_cur),
    .old_sample (ring_old),
    .threshold  (thr_r),
    .wr_entry   (chan_wr),
    .dev        (s1_dev),
    .prod       (s1_prod),
    .peak_raise (s1_raise)
  );

  always_comb begin
    s2_load.op         = s1_op_r;
    s2_load.ch         = s1_ch_r;
    s2_load.frame_end  = s1_end_r;
    s2_load.ch_ok      = s1_ok_r;
    s2_load.peak_raise = s1_raise && s1_ok_r;
    s2_load.dev        = s1_dev;
    s2_load.prod       = s1_prod;
  end

  wtd_frame #(
    .UNITS (UNITS)
  ) u_frame (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .s2_load_vld       (s1_valid_r),
    .s2_load           (s2_load),
    .unit_map          (umap_r),
    .grasp_mask        (gmask_r),
    .out_valid         (out_valid),
    .out_touched_units (out_touched_units),
    .out_grasp_touched (out_grasp_touched),
    .out_touch_started (out_touch_started),
    .out_touched_count (out_touched_count),
    .out_peak_changed  (out_peak_changed)
  );

  a_ring_fwd_same_chan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_ring_r |-> s1_fwd_chan_r)
    else $error("ring forward without channel forward");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ring_we |-> ({1'b0, s1_ring_addr_r[wtd_pkg::PTR_W-1:0]} <
                    (wtd_pkg::PTR_W + 1)'(WINDOW)))
    else $error("ring slot beyond window");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r))
    else $error("stage one moved while stalled");

endmodule

// ===== rtl/wtd_ram.sv =====
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Used for the sample ring and the per-channel sum/peak table. No dependencies.
module wtd_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 12,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wtd_update.sv =====
// Stage-one arithmetic: ring sum update, scaled deviation, peak raise and
// the threshold-times-peak product. Depends on wtd_pkg.
module wtd_update #(
  parameter int unsigned WINDOW = 16
) (
  input  wtd_pkg::op_t                    op,
  input  logic [wtd_pkg::SAMPLE_W-1:0]    x,
  input  wtd_pkg::chan_entry_t            cur,
  input  logic [wtd_pkg::SAMPLE_W-1:0]    old_sample,
  input  logic [wtd_pkg::THR_W-1:0]       threshold,
  output wtd_pkg::chan_entry_t            wr_entry,
  output logic [wtd_pkg::SUM_W-1:0]       dev,
  output logic [wtd_pkg::PROD_W-1:0]      prod,
  output logic                            peak_raise
);

  localparam int unsigned XPAD_W = wtd_pkg::SUM_W - wtd_pkg::SAMPLE_W;

  logic [wtd_pkg::SUM_W-1:0] x_ext;
  logic [wtd_pkg::SUM_W-1:0] scaled;
  logic [wtd_pkg::SUM_W-1:0] new_sum;
  logic [wtd_pkg::SUM_W-1:0] sum_used;
  logic                      feeds;

  always_comb begin
    x_ext    = {{XPAD_W{1'b0}}, x};
    scaled   = x_ext * wtd_pkg::SUM_W'(WINDOW);
    new_sum  = cur.sum + x_ext - {{XPAD_W{1'b0}}, old_sample};
    feeds    = (op == wtd_pkg::OP_BASELINE) || (op == wtd_pkg::OP_DETECT);
    sum_used = (op == wtd_pkg::OP_DETECT) ? new_sum : cur.sum;
    dev      = (scaled >= sum_used) ? (scaled - sum_used) : (sum_used - scaled);
    peak_raise    = (op == wtd_pkg::OP_CALIBRATE) && (dev > cur.peak);
    wr_entry.sum  = feeds ? new_sum : cur.sum;
    wr_entry.peak = peak_raise ? dev : cur.peak;
    prod = wtd_pkg::PROD_W'(threshold) * wtd_pkg::PROD_W'(cur.peak);
  end

endmodule

// ===== rtl/wtd_frame.sv =====
// Stage two and result register: touch compare, unit/grasp accumulation,
// touch-start edge and frame report with output stall. Depends on wtd_pkg.
module wtd_frame #(
  parameter int unsigned UNITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            s2_load_vld,
  input  wtd_pkg::s2_item_t               s2_load,
  input  logic [wtd_pkg::MAP_W-1:0]       unit_map,
  input  logic [wtd_pkg::UMASK_W-1:0]     grasp_mask,
  output logic                            out_valid,
  output logic [wtd_pkg::UMASK_W-1:0]     out_touched_units,
  output logic                            out_grasp_touched,
  output logic                            out_touch_started,
  output logic [wtd_pkg::COUNT_W-1:0]     out_touched_count,
  output logic                            out_peak_changed
);

  logic                            s2_vld_r;
  wtd_pkg::s2_item_t               s2_r;
  logic [wtd_pkg::UMASK_W-1:0]     mask_r, mask_nxt;
  logic                            grasp_r, grasp_nxt;
  logic                            pk_r, pk_nxt;
  logic                            prev_r, prev_nxt;
  logic                            ovld_r, ovld_nxt;
  logic [wtd_pkg::UMASK_W-1:0]     o_units_r;
  logic                            o_grasp_r;
  logic                            o_start_r;
  logic [wtd_pkg::COUNT_W-1:0]     o_count_r, count_nxt;
  logic                            o_pk_r;

  logic [wtd_pkg::UNIT_W-1:0]      unit;
  logic                            unit_ok;
  logic                            touch;
  logic                            hit;
  logic [wtd_pkg::PROD_W-1:0]      dev_scaled;
  logic                            now;
  logic                            is_end;

  always_comb begin
    unit       = unit_map[{s2_r.ch, 2'b00} +: wtd_pkg::UNIT_W];
    unit_ok    = {1'b0, unit} < (wtd_pkg::UNIT_W + 1)'(UNITS);
    dev_scaled = {{(wtd_pkg::PROD_W - wtd_pkg::SUM_W - wtd_pkg::DEV_FRAC_W){1'b0}},
                  s2_r.dev, {wtd_pkg::DEV_FRAC_W{1'b0}}};
    touch = s2_vld_r && (s2_r.op == wtd_pkg::OP_DETECT) && s2_r.ch_ok
            && (dev_scaled > s2_r.prod);
    hit   = touch && unit_ok;

    mask_nxt  = mask_r;
    grasp_nxt = grasp_r | (hit && grasp_mask[unit]);
    if (hit) begin
      mask_nxt[unit] = 1'b1;
    end
    pk_nxt = pk_r | (s2_vld_r && s2_r.peak_raise);
    now    = mask_nxt != '0;
    is_end = s2_vld_r && s2_r.frame_end;

    count_nxt = '0;
    for (int i = 0; i < wtd_pkg::UMASK_W; i++) begin
      count_nxt = count_nxt + wtd_pkg::COUNT_W'(mask_nxt[i]);
    end

    prev_nxt = prev_r;
    if (s2_vld_r && (s2_r.op == wtd_pkg::OP_RESET)) begin
      prev_nxt = 1'b0;
    end else if (is_end && (s2_r.op == wtd_pkg::OP_DETECT)) begin
      prev_nxt = now;
    end
    ovld_nxt = is_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      mask_r   <= '0;
      grasp_r  <= 1'b0;
      pk_r     <= 1'b0;
      prev_r   <= 1'b0;
      ovld_r   <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s2_load_vld;
      prev_r   <= prev_nxt;
      ovld_r   <= ovld_nxt;
      if (is_end) begin
        mask_r  <= '0;
        grasp_r <= 1'b0;
        pk_r    <= 1'b0;
      end else begin
        mask_r  <= mask_nxt;
        grasp_r <= grasp_nxt;
        pk_r    <= pk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_load;
      if (is_end) begin
        o_units_r <= mask_nxt;
        o_grasp_r <= grasp_nxt;
        o_start_r <= (s2_r.op == wtd_pkg::OP_DETECT) && now && !prev_r;
        o_count_r <= count_nxt;
        o_pk_r    <= pk_nxt;
      end
    end
  end

  assign out_valid         = ovld_r;
  assign out_touched_units = o_units_r;
  assign out_grasp_touched = o_grasp_r;
  assign out_touch_started = o_start_r;
  assign out_touched_count = o_count_r;
  assign out_peak_changed  = o_pk_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (o_count_r == wtd_pkg::COUNT_W'($countones(o_units_r))))
    else $error("touched count disagrees with unit mask");

  a_start_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && o_start_r) |-> (o_units_r != '0))
    else $error("touch start reported with no unit touched");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_end) |=> ((mask_r == '0) && !grasp_r && !pk_r))
    else $error("frame accumulators not cleared after frame end");

endmodule
